### sv/ilx_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ilx_pkg
// Shared types, constants and the keyword check for the identifier and
// number lexer.
// ----------------------------------------------------------------------------
package ilx_pkg;

   localparam int KEYWORD_CHARS  = 5;
   localparam int PREFIX_BITS    = KEYWORD_CHARS * 8;
   localparam int POSITION_BITS  = 16;
   localparam int QUEUE_DEPTH    = 4;
   localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);

   localparam logic [7:0] CH_UPPER_A = 8'h41;
   localparam logic [7:0] CH_LOWER_Z = 8'h7a;
   localparam logic [7:0] CH_UNDER   = 8'h5f;
   localparam logic [7:0] CH_ZERO    = 8'h30;
   localparam logic [7:0] CH_NINE    = 8'h39;
   localparam logic [7:0] CH_DOT     = 8'h2e;
   localparam logic [7:0] CH_HASH    = 8'h23;
   localparam logic [7:0] CH_NEWLINE = 8'h0a;

   // keywords packed first character in the low byte
   localparam logic [PREFIX_BITS-1:0] KW_IF    = PREFIX_BITS'(40'h00_0000_6669);
   localparam logic [PREFIX_BITS-1:0] KW_FOR   = PREFIX_BITS'(40'h00_0072_6f66);
   localparam logic [PREFIX_BITS-1:0] KW_WHILE = PREFIX_BITS'(40'h65_6c69_6877);
   localparam logic [PREFIX_BITS-1:0] KW_DO    = PREFIX_BITS'(40'h00_0000_6f64);
   localparam logic [PREFIX_BITS-1:0] KW_TRUE  = PREFIX_BITS'(40'h00_6575_7274);
   localparam logic [PREFIX_BITS-1:0] KW_FALSE = PREFIX_BITS'(40'h65_736c_6166);

   typedef enum logic [2:0] {
      KIND_IDENT = 3'd0,
      KIND_IF    = 3'd1,
      KIND_FOR   = 3'd2,
      KIND_WHILE = 3'd3,
      KIND_DO    = 3'd4,
      KIND_BOOL  = 3'd5,
      KIND_INT   = 3'd6,
      KIND_FLOAT = 3'd7
   } kind_type;

   typedef struct packed {
      kind_type    kind;
      logic [15:0] line;
      logic [15:0] column;
      logic [7:0]  length;
      logic        bad;
   } token_type;

   typedef struct packed {
      token_type first;
      token_type second;
      logic      two;
   } entry_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   function automatic kind_type ident_kind(input logic [7:0] len,
                                           input logic [PREFIX_BITS-1:0] prefix);
      kind_type k;
      k = KIND_IDENT;
      if (len == 8'd2 && prefix == KW_IF)         k = KIND_IF;
      else if (len == 8'd3 && prefix == KW_FOR)   k = KIND_FOR;
      else if (len == 8'd5 && prefix == KW_WHILE) k = KIND_WHILE;
      else if (len == 8'd2 && prefix == KW_DO)    k = KIND_DO;
      else if (len == 8'd4 && prefix == KW_TRUE)  k = KIND_BOOL;
      else if (len == 8'd5 && prefix == KW_FALSE) k = KIND_BOOL;
      return k;
   endfunction

endpackage

### sv/identifier_number_lexer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// identifier_number_lexer
// Streaming lexer for identifiers, numbers and keywords with line and
// column tracking.
// ----------------------------------------------------------------------------
// One character is taken per cycle whenever the four-entry token queue has
// room; the scanner updates position and token state for that character in
// the same cycle. Tokens leave through a registered output at one per cycle
// while the output does not stall, so a character that closes one token and
// starts another that ends at end of text gives two tokens, and the queue
// fills only when the output side stalls or such characters come in a row.
// Tokens pass the queue, then the output register. Once a number with a
// second dot is reported, characters are taken but dropped until reset.
module identifier_number_lexer
   import ilx_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_ch,
   input  logic        req_end_of_text,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_kind,
   output logic [15:0] rsp_start_line,
   output logic [15:0] rsp_start_column,
   output logic [7:0]  rsp_length,
   output logic        rsp_bad_number,
   output logic        rsp_last
);

   queue_status_type q_status;
   logic             q_push, q_pop;
   entry_type        q_entry, q_head;

   ilx_scan u_scan (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_ch          (req_ch),
      .req_end_of_text (req_end_of_text),
      .q_status        (q_status),
      .q_push          (q_push),
      .q_entry         (q_entry)
   );

   ilx_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .q_push   (q_push),
      .q_entry  (q_entry),
      .q_pop    (q_pop),
      .q_status (q_status),
      .q_head   (q_head)
   );

   ilx_emit u_emit (
      .clock            (clock),
      .reset            (reset),
      .q_status         (q_status),
      .q_head           (q_head),
      .q_pop            (q_pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_kind         (rsp_kind),
      .rsp_start_line   (rsp_start_line),
      .rsp_start_column (rsp_start_column),
      .rsp_length       (rsp_length),
      .rsp_bad_number   (rsp_bad_number),
      .rsp_last         (rsp_last)
   );

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_status.full)
      else $error("token pushed into a full queue");

   a_bad_is_last_float: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_bad_number) |-> (rsp_last && rsp_kind == KIND_FLOAT))
      else $error("bad number token not final float");

   a_token_nonempty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_length != '0 && rsp_start_line != '0))
      else $error("token with zero length or line");

   a_no_pop_when_empty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_status.empty)
      else $error("token popped from an empty queue");

endmodule

### sv/ilx_scan.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ilx_scan
// Front end: takes one character per transfer, tracks position and token
// state, and pushes the one or two tokens it causes as one queue entry.
// ----------------------------------------------------------------------------
module ilx_scan
   import ilx_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  logic [7:0]       req_ch,
   input  logic             req_end_of_text,
   input  queue_status_type q_status,
   output logic             q_push,
   output entry_type        q_entry
);

   typedef enum logic [2:0] {
      MODE_IDLE,
      MODE_IDENT,
      MODE_NUMBER,
      MODE_COMMENT,
      MODE_HALT
   } mode_type;

   mode_type                 mode_ff, mode_in;
   logic [POSITION_BITS-1:0] line_ff, line_in;
   logic [POSITION_BITS-1:0] col_ff, col_in;
   logic [POSITION_BITS-1:0] tline_ff, tline_in;
   logic [POSITION_BITS-1:0] tcol_ff, tcol_in;
   logic [7:0]               tlen_ff, tlen_in;
   logic [PREFIX_BITS-1:0]   prefix_ff, prefix_in;
   logic                     dot_ff, dot_in;

   logic      accept;
   logic [1:0] n;
   token_type r0, r1, t;
   logic      is_ident, is_digit, restart, append, halted;

   assign req_stall = q_status.full;
   assign accept    = req_valid && !req_stall;
   assign is_ident  = req_ch inside {[CH_UPPER_A:CH_LOWER_Z]};
   assign is_digit  = req_ch inside {[CH_ZERO:CH_NINE]};

   always_comb begin
      mode_in   = mode_ff;
      line_in   = line_ff;
      col_in    = col_ff;
      tline_in  = tline_ff;
      tcol_in   = tcol_ff;
      tlen_in   = tlen_ff;
      prefix_in = prefix_ff;
      dot_in    = dot_ff;
      n         = 2'd0;
      r0        = '0;
      r1        = '0;
      t         = '0;
      restart   = 1'b0;
      append    = 1'b0;
      halted    = 1'b0;
      if (mode_ff != MODE_HALT) begin
         if (req_ch == CH_NEWLINE) begin
            if (line_in != '1) line_in = line_in + 1'b1;
            col_in = '0;
         end else if (col_in != '1) begin
            col_in = col_in + 1'b1;
         end
         // token that a non-extending character closes
         t.line   = 16'(tline_ff);
         t.column = 16'(tcol_ff);
         t.length = tlen_ff;
         t.bad    = 1'b0;
         t.kind   = (mode_ff == MODE_IDENT) ? ident_kind(tlen_ff, prefix_ff) :
                    (dot_ff ? KIND_FLOAT : KIND_INT);
         case (mode_ff)
            MODE_COMMENT: begin
               if (req_ch == CH_NEWLINE) mode_in = MODE_IDLE;
            end
            MODE_IDENT: begin
               if (is_ident) begin
                  append = 1'b1;
               end else begin
                  r0      = t;
                  n       = 2'd1;
                  restart = 1'b1;
               end
            end
            MODE_NUMBER: begin
               if (is_digit) begin
                  append = 1'b1;
               end else if (req_ch == CH_DOT) begin
                  append = 1'b1;
                  if (dot_ff) begin
                     r0.line   = 16'(tline_ff);
                     r0.column = 16'(tcol_ff);
                     r0.length = (tlen_ff != 8'hff) ? tlen_ff + 1'b1 : tlen_ff;
                     r0.kind   = KIND_FLOAT;
                     r0.bad    = 1'b1;
                     n         = 2'd1;
                     halted    = 1'b1;
                     mode_in   = MODE_HALT;
                  end else begin
                     dot_in = 1'b1;
                  end
               end else begin
                  r0      = t;
                  n       = 2'd1;
                  restart = 1'b1;
               end
            end
            default: restart = 1'b1;
         endcase
         if (restart) begin
            if (is_ident || is_digit) begin
               mode_in   = is_digit ? MODE_NUMBER : MODE_IDENT;
               tline_in  = line_in;
               tcol_in   = col_in;
               tlen_in   = '0;
               prefix_in = '0;
               dot_in    = 1'b0;
               append    = 1'b1;
            end else if (req_ch == CH_HASH) begin
               mode_in = MODE_COMMENT;
            end else begin
               mode_in = MODE_IDLE;
            end
         end
         if (append) begin
            for (int i = 0; i < KEYWORD_CHARS; i++) begin
               if (tlen_in == 8'(i)) prefix_in[i*8 +: 8] = req_ch;
            end
            if (tlen_in != 8'hff) tlen_in = tlen_in + 1'b1;
         end
         if (req_end_of_text && !halted) begin
            t.line   = 16'(tline_in);
            t.column = 16'(tcol_in);
            t.length = tlen_in;
            t.bad    = 1'b0;
            t.kind   = (mode_in == MODE_IDENT) ? ident_kind(tlen_in, prefix_in) :
                       (dot_in ? KIND_FLOAT : KIND_INT);
            if (mode_in == MODE_IDENT || mode_in == MODE_NUMBER) begin
               if (n == 2'd0) r0 = t;
               else r1 = t;
               n = n + 1'b1;
            end
            mode_in = MODE_IDLE;
            line_in = POSITION_BITS'(1);
            col_in  = '0;
         end
      end
   end

   assign q_push         = accept && (n != 2'd0);
   assign q_entry.first  = r0;
   assign q_entry.second = r1;
   assign q_entry.two    = (n == 2'd2);

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_IDLE;
         line_ff   <= POSITION_BITS'(1);
         col_ff    <= '0;
         tline_ff  <= POSITION_BITS'(1);
         tcol_ff   <= POSITION_BITS'(1);
         tlen_ff   <= '0;
         prefix_ff <= '0;
         dot_ff    <= 1'b0;
      end else if (accept) begin
         mode_ff   <= mode_in;
         line_ff   <= line_in;
         col_ff    <= col_in;
         tline_ff  <= tline_in;
         tcol_ff   <= tcol_in;
         tlen_ff   <= tlen_in;
         prefix_ff <= prefix_in;
         dot_ff    <= dot_in;
      end
   end

endmodule

### sv/ilx_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ilx_queue
// Short queue of token entries between the scanner and the emitter.
// ----------------------------------------------------------------------------
module ilx_queue
   import ilx_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             q_push,
   input  entry_type        q_entry,
   input  logic             q_pop,
   output queue_status_type q_status,
   output entry_type        q_head
);

   entry_type                 mem_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_BITS-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [QUEUE_PTR_BITS:0]   count_ff, count_in;

   assign q_status.full  = (count_ff == (QUEUE_PTR_BITS+1)'(QUEUE_DEPTH));
   assign q_status.empty = (count_ff == '0);
   assign q_head         = mem_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (q_push && !q_pop) count_in = count_ff + 1'b1;
      else if (q_pop && !q_push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (q_push) wr_ptr_ff <= wr_ptr_ff + 1'b1;
         if (q_pop) rd_ptr_ff <= rd_ptr_ff + 1'b1;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_push) mem_ff[wr_ptr_ff] <= q_entry;
   end

endmodule

### sv/ilx_emit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ilx_emit
// Back end: drains queue entries one token per transfer into the output
// register and marks the last token of each entry.
// ----------------------------------------------------------------------------
module ilx_emit
   import ilx_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  queue_status_type q_status,
   input  entry_type        q_head,
   output logic             q_pop,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic [2:0]       rsp_kind,
   output logic [15:0]      rsp_start_line,
   output logic [15:0]      rsp_start_column,
   output logic [7:0]       rsp_length,
   output logic             rsp_bad_number,
   output logic             rsp_last
);

   logic      valid_ff, sel_ff, last_ff;
   token_type tok_ff;
   logic      out_free, load, is_last;
   token_type cur;

   assign out_free = !valid_ff || !rsp_stall;
   assign load     = out_free && !q_status.empty;
   assign cur      = sel_ff ? q_head.second : q_head.first;
   assign is_last  = !q_head.two || sel_ff;
   assign q_pop    = load && is_last;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         sel_ff   <= 1'b0;
      end else begin
         if (out_free) valid_ff <= !q_status.empty;
         if (load) sel_ff <= !is_last;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         tok_ff  <= cur;
         last_ff <= is_last;
      end
   end

   assign rsp_valid        = valid_ff;
   assign rsp_kind         = tok_ff.kind;
   assign rsp_start_line   = tok_ff.line;
   assign rsp_start_column = tok_ff.column;
   assign rsp_length       = tok_ff.length;
   assign rsp_bad_number   = tok_ff.bad;
   assign rsp_last         = last_ff;

endmodule

### test/tb_identifier_number_lexer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_identifier_number_lexer
// Self-checking bench for the identifier and number lexer. Characters are
// sent in bursts with random gaps while the token side stalls on its own
// pattern. A scanner model in the bench predicts every token transfer and a
// checker compares each transfer field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module tb_identifier_number_lexer
   import ilx_pkg::*;
();

   localparam int CYCLE_LIMIT = 200_000;

   typedef enum logic [2:0] {
      SCAN_IDLE,
      SCAN_IDENT,
      SCAN_NUMBER,
      SCAN_COMMENT,
      SCAN_HALT
   } scan_mode_type;

   typedef struct {
      kind_type    kind;
      logic [15:0] line;
      logic [15:0] column;
      logic [7:0]  length;
      logic        bad;
      logic        last;
   } token_check_type;

   logic        clock           = 1'b0;
   logic        reset           = 1'b1;
   logic        req_valid       = 1'b0;
   logic        req_stall;
   logic [7:0]  req_ch          = 8'h00;
   logic        req_end_of_text = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall       = 1'b0;
   logic [2:0]  rsp_kind;
   logic [15:0] rsp_start_line;
   logic [15:0] rsp_start_column;
   logic [7:0]  rsp_length;
   logic        rsp_bad_number;
   logic        rsp_last;

   identifier_number_lexer uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_ch           (req_ch),
      .req_end_of_text  (req_end_of_text),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_kind         (rsp_kind),
      .rsp_start_line   (rsp_start_line),
      .rsp_start_column (rsp_start_column),
      .rsp_length       (rsp_length),
      .rsp_bad_number   (rsp_bad_number),
      .rsp_last         (rsp_last)
   );

   always #10 clock = ~clock;

   scan_mode_type             scan_mode  = SCAN_IDLE;
   logic [POSITION_BITS-1:0]  line_pos   = POSITION_BITS'(1);
   logic [POSITION_BITS-1:0]  col_pos    = '0;
   logic [POSITION_BITS-1:0]  tok_line   = POSITION_BITS'(1);
   logic [POSITION_BITS-1:0]  tok_col    = POSITION_BITS'(1);
   logic [7:0]                tok_len    = '0;
   logic [PREFIX_BITS-1:0]    tok_prefix = '0;
   logic                      tok_dot    = 1'b0;

   token_check_type pending_tokens[$];
   token_check_type step_tokens[$];
   token_check_type head_token;
   int              failures    = 0;
   int              burst_left  = 0;
   int unsigned     cycle_count = 0;
   int              stall_left  = 0;
   int              stall_style = 0;

   function automatic bit is_ident(input logic [7:0] c);
      return c >= CH_UPPER_A && c <= CH_LOWER_Z;
   endfunction

   function automatic bit is_digit(input logic [7:0] c);
      return c >= CH_ZERO && c <= CH_NINE;
   endfunction

   function automatic kind_type keyword_kind();
      case (tok_len)
         8'd2: begin
            if (tok_prefix == KW_IF) return KIND_IF;
            if (tok_prefix == KW_DO) return KIND_DO;
         end
         8'd3: begin
            if (tok_prefix == KW_FOR) return KIND_FOR;
         end
         8'd4: begin
            if (tok_prefix == KW_TRUE) return KIND_BOOL;
         end
         8'd5: begin
            if (tok_prefix == KW_WHILE) return KIND_WHILE;
            if (tok_prefix == KW_FALSE) return KIND_BOOL;
         end
         default: ;
      endcase
      return KIND_IDENT;
   endfunction

   function automatic void push_token(input kind_type kind, input logic bad);
      token_check_type t;
      t.kind   = kind;
      t.line   = 16'(tok_line);
      t.column = 16'(tok_col);
      t.length = tok_len;
      t.bad    = bad;
      t.last   = 1'b0;
      step_tokens.insert(step_tokens.size(), t);
   endfunction

   function automatic void grow_token(input logic [7:0] c);
      if (tok_len < KEYWORD_CHARS)
         tok_prefix = tok_prefix | (PREFIX_BITS'(c) << (8 * tok_len));
      if (tok_len != 8'hff)
         tok_len = tok_len + 8'd1;
   endfunction

   function automatic void close_token();
      if (scan_mode == SCAN_IDENT)
         push_token(keyword_kind(), 1'b0);
      else if (scan_mode == SCAN_NUMBER)
         push_token(tok_dot ? KIND_FLOAT : KIND_INT, 1'b0);
   endfunction

   function automatic void open_token(input logic [7:0] c);
      if (is_ident(c) || is_digit(c)) begin
         scan_mode  = is_digit(c) ? SCAN_NUMBER : SCAN_IDENT;
         tok_line   = line_pos;
         tok_col    = col_pos;
         tok_len    = '0;
         tok_prefix = '0;
         tok_dot    = 1'b0;
         grow_token(c);
      end else if (c == CH_HASH) begin
         scan_mode = SCAN_COMMENT;
      end else begin
         scan_mode = SCAN_IDLE;
      end
   endfunction

   function automatic void predict_tokens(input logic [7:0] c, input logic eot);
      step_tokens = {};
      if (scan_mode == SCAN_HALT) return;
      if (c == CH_NEWLINE) begin
         if (line_pos != '1) line_pos = line_pos + 1'b1;
         col_pos = '0;
      end else if (col_pos != '1) begin
         col_pos = col_pos + 1'b1;
      end
      case (scan_mode)
         SCAN_COMMENT: begin
            if (c == CH_NEWLINE) scan_mode = SCAN_IDLE;
         end
         SCAN_IDENT: begin
            if (is_ident(c)) begin
               grow_token(c);
            end else begin
               close_token();
               open_token(c);
            end
         end
         SCAN_NUMBER: begin
            if (is_digit(c)) begin
               grow_token(c);
            end else if (c == CH_DOT) begin
               grow_token(c);
               if (tok_dot) begin
                  push_token(KIND_FLOAT, 1'b1);
                  scan_mode = SCAN_HALT;
               end else begin
                  tok_dot = 1'b1;
               end
            end else begin
               close_token();
               open_token(c);
            end
         end
         default: open_token(c);
      endcase
      if (eot && scan_mode != SCAN_HALT) begin
         close_token();
         scan_mode = SCAN_IDLE;
         line_pos  = POSITION_BITS'(1);
         col_pos   = '0;
      end
      if (step_tokens.size() > 0) step_tokens[$].last = 1'b1;
      foreach (step_tokens[i]) pending_tokens.insert(pending_tokens.size(), step_tokens[i]);
   endfunction

   task automatic send_char(input logic [7:0] c, input logic eot);
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(0, 6);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 40);
      end
      burst_left--;
      req_valid       <= 1'b1;
      req_ch          <= c;
      req_end_of_text <= eot;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_tokens(c, eot);
   endtask

   task automatic send_text(input string s, input bit eot);
      for (int i = 0; i < s.len(); i++)
         send_char(s[i], eot && i == s.len() - 1);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (pending_tokens.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   function automatic string keyword_text(input int idx);
      case (idx)
         0: return "if";
         1: return "for";
         2: return "while";
         3: return "do";
         4: return "true";
         default: return "false";
      endcase
   endfunction

   function automatic logic [7:0] noise_byte();
      logic [7:0] b;
      do
         b = 8'($urandom);
      while (b == CH_DOT || is_ident(b) || is_digit(b));
      return b;
   endfunction

   function automatic logic [7:0] separator_byte();
      case ($urandom_range(0, 3))
         0: return 8'h20;
         1: return 8'h09;
         2: return CH_NEWLINE;
         default: return noise_byte();
      endcase
   endfunction

   task automatic test_keywords();
      send_text("if for\nwhile do true false whilex If", 1'b1);
      drain();
   endtask

   task automatic test_numbers();
      send_text("0 9 12.5 7. 3a.", 1'b1);
      drain();
   endtask

   task automatic test_char_edges();
      logic [7:0] edge_chars[$];
      edge_chars = '{8'h40, CH_UPPER_A, CH_UNDER, CH_LOWER_Z, 8'h7b, 8'h2f, CH_ZERO,
                     CH_NINE, 8'h3a, 8'hff, 8'h00, 8'h80};
      foreach (edge_chars[i])
         send_char(edge_chars[i], i == edge_chars.size() - 1);
      drain();
   endtask

   task automatic test_comments();
      send_text("a#x if\n b#\tq 5", 1'b1);
      drain();
   endtask

   // end of text on a character that closes one token and opens another
   task automatic test_two_tokens_at_end();
      send_text("x1", 1'b1);
      send_text("5q", 1'b1);
      send_text("q", 1'b1);
      send_text(" ", 1'b1);
      send_text("\nz", 1'b1);
      drain();
   endtask

   task automatic test_length_saturation();
      for (int i = 0; i < 258; i++) send_char(8'h77, i == 257);
      for (int i = 0; i < 257; i++) send_char(CH_NINE, i == 256);
      drain();
   endtask

   task automatic test_random_text(input int target);
      int         sent;
      int         pick;
      int         n;
      bit         is_number;
      string      word;
      logic [7:0] b;
      logic [7:0] chunk[$];
      sent = 0;
      while (sent < target) begin
         chunk     = {};
         is_number = 1'b0;
         pick      = $urandom_range(0, 99);
         if (pick < 15) begin
            word = keyword_text($urandom_range(0, 5));
            for (int i = 0; i < word.len(); i++) chunk.insert(chunk.size(), word[i]);
            if ($urandom_range(0, 4) == 0)
               chunk.insert(chunk.size(), 8'($urandom_range(CH_UPPER_A, CH_LOWER_Z)));
            else if ($urandom_range(0, 4) == 0) void'(chunk.pop_back());
         end else if (pick < 45) begin
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(6, 12) : $urandom_range(1, 6);
            repeat (n) chunk.insert(chunk.size(), 8'($urandom_range(CH_UPPER_A, CH_LOWER_Z)));
         end else if (pick < 70) begin
            is_number = 1'b1;
            n = $urandom_range(1, 5);
            repeat (n) chunk.insert(chunk.size(), 8'($urandom_range(CH_ZERO, CH_NINE)));
            if ($urandom_range(0, 4) < 2) chunk.insert($urandom_range(1, n), CH_DOT);
         end else if (pick < 80) begin
            chunk.insert(chunk.size(), CH_HASH);
            repeat ($urandom_range(0, 10)) begin
               do
                  b = 8'($urandom);
               while (b == CH_NEWLINE);
               chunk.insert(chunk.size(), b);
            end
            if ($urandom_range(0, 4) < 3) chunk.insert(chunk.size(), CH_NEWLINE);
         end else if (pick < 90) begin
            chunk.insert(chunk.size(), noise_byte());
         end else begin
            chunk.insert(chunk.size(), separator_byte());
         end
         if (is_number || $urandom_range(0, 9) < 7) chunk.insert(chunk.size(), separator_byte());
         pick = $urandom_range(0, 99);
         foreach (chunk[i])
            send_char(chunk[i], pick < 6 && i == chunk.size() - 1);
         sent += chunk.size();
      end
      drain();
   endtask

   // the block stays halted after this, so it runs last
   task automatic test_second_dot_halt();
      send_text("8 5.5.", 1'b1);
      send_text("ab 12 if", 1'b1);
      drain();
   endtask

   always @(posedge clock) begin
      if (stall_left == 0) begin
         stall_style <= $urandom_range(0, 3);
         stall_left  <= $urandom_range(5, 60);
      end else begin
         stall_left <= stall_left - 1;
      end
      case (stall_style)
         0: rsp_stall <= 1'b0;
         1: rsp_stall <= ($urandom_range(0, 3) == 0);
         2: rsp_stall <= ($urandom_range(0, 3) != 0);
         default: rsp_stall <= 1'b1;
      endcase
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_tokens.size() == 0) begin
            $error("token transfer with nothing expected: kind %0d line %0d column %0d",
                   rsp_kind, rsp_start_line, rsp_start_column);
            failures++;
         end else begin
            head_token = pending_tokens.pop_front();
            if (rsp_kind !== head_token.kind) begin
               $error("kind expected %0d actual %0d", head_token.kind, rsp_kind);
               failures++;
            end
            if (rsp_start_line !== head_token.line) begin
               $error("start_line expected %0d actual %0d", head_token.line, rsp_start_line);
               failures++;
            end
            if (rsp_start_column !== head_token.column) begin
               $error("start_column expected %0d actual %0d", head_token.column,
                      rsp_start_column);
               failures++;
            end
            if (rsp_length !== head_token.length) begin
               $error("length expected %0d actual %0d", head_token.length, rsp_length);
               failures++;
            end
            if (rsp_bad_number !== head_token.bad) begin
               $error("bad_number expected %0d actual %0d", head_token.bad, rsp_bad_number);
               failures++;
            end
            if (rsp_last !== head_token.last) begin
               $error("last expected %0d actual %0d", head_token.last, rsp_last);
               failures++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      test_keywords();
      test_numbers();
      test_char_edges();
      test_comments();
      test_two_tokens_at_end();
      test_length_saturation();
      test_random_text(240);
      test_second_dot_halt();
      if (failures == 0 && pending_tokens.size() == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
